// File: rtl/core/cvuc_pkg.sv
// Shared types, constants and keyword tables of the command-line video usecase classifier.
// No dependencies; used by cvuc_scan and cmdline_video_usecase_classifier.
package cvuc_pkg;

  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam logic [LIMIT_W-1:0] SMALL_LIMIT_RESET = 16'd720;
  localparam logic [LIMIT_W-1:0] MID_LIMIT_RESET = 16'd1080;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SMALL_LIMIT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MID_LIMIT = 2'd1;

  // Usecase codes
  typedef logic [2:0] usecase_t;
  localparam usecase_t UC_NONE      = 3'd0;
  localparam usecase_t UC_DECODE    = 3'd1;
  localparam usecase_t UC_ENC_SMALL = 3'd2;
  localparam usecase_t UC_ENC_MID   = 3'd3;
  localparam usecase_t UC_ENC_LARGE = 3'd4;
  localparam usecase_t UC_ENC_MANY  = 3'd5;
  localparam usecase_t UC_ENC_DEC   = 3'd6;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_E     = 8'h65;

  // Keyword lengths
  localparam logic [3:0] ENC_LEN  = 4'd11;
  localparam logic [3:0] DEC_LEN  = 4'd11;
  localparam logic [3:0] PRV_LEN  = 4'd10;
  localparam logic [2:0] HKEY_LEN = 3'd7;

  // Keyword tables, padded with NUL; a NUL byte never reaches the matchers.
  localparam logic [7:0] ENC_KW [16] = '{
    8'h76, 8'h34, 8'h6C, 8'h32, 8'h68, 8'h32, 8'h36, 8'h34,
    8'h65, 8'h6E, 8'h63, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [7:0] DEC_KW [16] = '{
    8'h76, 8'h34, 8'h6C, 8'h32, 8'h68, 8'h32, 8'h36, 8'h34,
    8'h64, 8'h65, 8'h63, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [7:0] PRV_KW [16] = '{
    8'h71, 8'h74, 8'h69, 8'h71, 8'h6D, 8'h6D, 8'h66, 8'h73,
    8'h72, 8'h63, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [7:0] HKEY_KW [8] = '{
    8'h68, 8'h65, 8'h69, 8'h67, 8'h68, 8'h74, 8'h3D, 8'h00
  };

  // Beat handed from the input stage to the scanner
  typedef struct packed {
    logic       step;
    logic [7:0] text_byte;
    logic       is_last;
  } cvuc_beat_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] small_limit;
    logic [LIMIT_W-1:0] mid_limit;
  } cvuc_limits_t;

  // Matcher for the codec keywords: 'v' occurs only at their head,
  // so a mismatch falls back to one or zero.
  function automatic logic [3:0] codec_step(logic [3:0] pos, logic [7:0] exp_c,
                                            logic [7:0] c);
    logic [3:0] res;
    if (c == exp_c) begin
      res = pos + 4'd1;
    end else if (c == CH_V) begin
      res = 4'd1;
    end else begin
      res = 4'd0;
    end
    return res;
  endfunction

  // Preview keyword: 'q' recurs at position 3, so "qtiq" then 't' keeps "qt".
  function automatic logic [3:0] prv_step(logic [3:0] pos, logic [7:0] c);
    logic [3:0] res;
    if (c == PRV_KW[pos]) begin
      res = pos + 4'd1;
    end else if (pos == 4'd4 && c == CH_T) begin
      res = 4'd2;
    end else if (c == CH_Q) begin
      res = 4'd1;
    end else begin
      res = 4'd0;
    end
    return res;
  endfunction

  // Height key: 'h' recurs at position 4, so "heigh" then 'e' keeps "he".
  function automatic logic [2:0] hkey_step(logic [2:0] pos, logic [7:0] c);
    logic [2:0] res;
    if (c == HKEY_KW[pos]) begin
      res = pos + 3'd1;
    end else if (pos == 3'd5 && c == CH_E) begin
      res = 3'd2;
    end else if (c == CH_H) begin
      res = 3'd1;
    end else begin
      res = 3'd0;
    end
    return res;
  endfunction

endpackage

// File: rtl/core/cmdline_video_usecase_classifier.sv
// Top level of the command-line video usecase classifier: handshakes, limits, result register.
// Depends on cvuc_pkg and cvuc_scan.
//
// Usage:
//   The input stream carries one command-line byte per beat in in_tdata, with
//   in_tlast on the final byte of the line. A zero byte ends the string; bytes
//   after it are ignored until the beat with in_tlast. That last beat yields
//   exactly one output beat whose out_tdata holds the usecase code; no other
//   beat produces output. The scan state then clears for the next line.
//   The two height limits are written through cfg_wr_en / cfg_addr / cfg_wdata
//   while the block is idle; writes to other indexes are dropped.
// Timing:
//   One byte per cycle, sustained unless a last byte waits on a full output slot.
//   An accepted beat sits in the input register while the scanner updates its
//   matchers; on a last beat the usecase is captured in the output register as
//   the beat leaves the input register, which raises out_tvalid. The scanner
//   updates all matchers in one step, which is what sets the one-beat-per-cycle rate.
// Reset and stall:
//   rst_n (synchronous, active low) clears both stages, the scan state and sets
//   the limits to 720 and 1080. While out_tready is low with a result pending,
//   non-last bytes keep flowing; a second last byte holds in the input register
//   and in_tready drops until the pending result is taken.
module cmdline_video_usecase_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] text_byte
  input  logic                              in_tlast,   // is_last
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [2:0] usecase, [7:3] zero
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [cvuc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [cvuc_pkg::LIMIT_W-1:0]      cfg_wdata
);

  logic                   s1_valid_r, s1_valid_nxt;
  logic [7:0]             s1_byte_r;
  logic                   s1_last_r;
  logic                   s1_go;
  logic                   in_fire;
  logic                   out_valid_r, out_valid_nxt;
  cvuc_pkg::usecase_t     out_usecase_r;
  cvuc_pkg::usecase_t     usecase;
  cvuc_pkg::cvuc_beat_t   beat;
  cvuc_pkg::cvuc_limits_t limits_r;

  // Retire the held beat unless it needs the output slot and that slot is full
  assign s1_go     = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_go);
  assign out_valid_nxt = (out_valid_r && !out_tready) || (s1_go && s1_last_r);

  assign beat.step      = s1_go;
  assign beat.text_byte = s1_byte_r;
  assign beat.is_last   = s1_last_r;

  cvuc_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat    (beat),
    .limits  (limits_r),
    .usecase (usecase)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: advance on a fresh beat, capture the code on a last beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_go && s1_last_r) begin
      out_usecase_r <= usecase;
    end
  end

  // Height limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.small_limit <= cvuc_pkg::SMALL_LIMIT_RESET;
      limits_r.mid_limit   <= cvuc_pkg::MID_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        cvuc_pkg::CFG_SMALL_LIMIT: limits_r.small_limit <= cfg_wdata;
        cvuc_pkg::CFG_MID_LIMIT:   limits_r.mid_limit   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_usecase_r};

endmodule

// File: rtl/core/cvuc_scan.sv
// Scan state of the classifier: keyword matchers, height parser and usecase decision.
// Depends on cvuc_pkg.
module cvuc_scan (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cvuc_pkg::cvuc_beat_t    beat,
  input  cvuc_pkg::cvuc_limits_t  limits,
  output cvuc_pkg::usecase_t      usecase
);

  typedef enum logic [1:0] {HP_KEY, HP_SPACE, HP_DIGITS, HP_DONE} hphase_t;

  logic [3:0]  enc_pos_r, enc_pos_nxt, enc_pos_s;
  logic [3:0]  dec_pos_r, dec_pos_nxt, dec_pos_s;
  logic [3:0]  prv_pos_r, prv_pos_nxt, prv_pos_s;
  logic [2:0]  hkey_pos_r, hkey_pos_nxt, hkey_pos_s;
  logic [1:0]  enc_cnt_r, enc_cnt_nxt, enc_cnt_s;
  logic        dec_seen_r, dec_seen_nxt, dec_seen_s;
  logic [1:0]  prv_cnt_r, prv_cnt_nxt, prv_cnt_s;
  hphase_t     phase_r, phase_nxt, phase_s;
  logic        neg_r, neg_nxt, neg_s;
  logic [15:0] height_r, height_nxt, height_s;
  logic        ended_r, ended_nxt, ended_s;

  logic [7:0]  c;
  logic        is_ws;
  logic        is_digit;
  logic [3:0]  digit;
  logic [19:0] height_acc;
  logic [1:0]  enc_eff;
  logic        from_prv;
  logic [15:0] height_eff;

  assign c        = beat.text_byte;
  assign is_ws    = (c == cvuc_pkg::CH_SPACE) ||
                    (c >= cvuc_pkg::CH_TAB && c <= cvuc_pkg::CH_CR);
  assign is_digit = (c >= cvuc_pkg::CH_ZERO) && (c <= cvuc_pkg::CH_NINE);
  assign digit    = c[3:0];
  // value * 10 + digit, as (v << 3) + (v << 1) + d
  assign height_acc = {1'b0, height_r, 3'b000} + {3'b000, height_r, 1'b0}
                    + {16'd0, digit};

  always_comb begin
    enc_pos_s  = enc_pos_r;
    dec_pos_s  = dec_pos_r;
    prv_pos_s  = prv_pos_r;
    hkey_pos_s = hkey_pos_r;
    enc_cnt_s  = enc_cnt_r;
    dec_seen_s = dec_seen_r;
    prv_cnt_s  = prv_cnt_r;
    phase_s    = phase_r;
    neg_s      = neg_r;
    height_s   = height_r;
    ended_s    = ended_r;

    if (!ended_r) begin
      if (c == cvuc_pkg::CH_NUL) begin
        ended_s = 1'b1;
      end else begin
        unique case (phase_r)
          HP_KEY: begin
            hkey_pos_s = cvuc_pkg::hkey_step(hkey_pos_r, c);
            if (hkey_pos_s == cvuc_pkg::HKEY_LEN) begin
              hkey_pos_s = 3'd0;
              phase_s    = HP_SPACE;
            end
          end
          HP_SPACE: begin
            if (is_ws) begin
              phase_s = HP_SPACE;
            end else if (c == cvuc_pkg::CH_PLUS || c == cvuc_pkg::CH_MINUS) begin
              neg_s   = (c == cvuc_pkg::CH_MINUS);
              phase_s = HP_DIGITS;
            end else if (is_digit) begin
              height_s = {12'd0, digit};
              phase_s  = HP_DIGITS;
            end else begin
              phase_s = HP_DONE;
            end
          end
          HP_DIGITS: begin
            if (is_digit) begin
              height_s = (height_acc > 20'd65535) ? 16'hFFFF : height_acc[15:0];
            end else begin
              phase_s = HP_DONE;
            end
          end
          HP_DONE: begin
            phase_s = HP_DONE;
          end
        endcase

        enc_pos_s = cvuc_pkg::codec_step(enc_pos_r, cvuc_pkg::ENC_KW[enc_pos_r], c);
        if (enc_pos_s == cvuc_pkg::ENC_LEN) begin
          enc_pos_s = 4'd0;
          if (enc_cnt_r != 2'd2) begin
            enc_cnt_s = enc_cnt_r + 2'd1;
          end
        end
        dec_pos_s = cvuc_pkg::codec_step(dec_pos_r, cvuc_pkg::DEC_KW[dec_pos_r], c);
        if (dec_pos_s == cvuc_pkg::DEC_LEN) begin
          dec_pos_s  = 4'd0;
          dec_seen_s = 1'b1;
        end
        prv_pos_s = cvuc_pkg::prv_step(prv_pos_r, c);
        if (prv_pos_s == cvuc_pkg::PRV_LEN) begin
          prv_pos_s = 4'd0;
          if (prv_cnt_r != 2'd2) begin
            prv_cnt_s = prv_cnt_r + 2'd1;
          end
        end
      end
    end

    // Clear the scan after the last byte of a line
    if (beat.is_last) begin
      enc_pos_nxt  = 4'd0;
      dec_pos_nxt  = 4'd0;
      prv_pos_nxt  = 4'd0;
      hkey_pos_nxt = 3'd0;
      enc_cnt_nxt  = 2'd0;
      dec_seen_nxt = 1'b0;
      prv_cnt_nxt  = 2'd0;
      phase_nxt    = HP_KEY;
      neg_nxt      = 1'b0;
      height_nxt   = 16'd0;
      ended_nxt    = 1'b0;
    end else begin
      enc_pos_nxt  = enc_pos_s;
      dec_pos_nxt  = dec_pos_s;
      prv_pos_nxt  = prv_pos_s;
      hkey_pos_nxt = hkey_pos_s;
      enc_cnt_nxt  = enc_cnt_s;
      dec_seen_nxt = dec_seen_s;
      prv_cnt_nxt  = prv_cnt_s;
      phase_nxt    = phase_s;
      neg_nxt      = neg_s;
      height_nxt   = height_s;
      ended_nxt    = ended_s;
    end
  end

  // Usecase decision on the state after this byte
  always_comb begin
    from_prv   = (enc_cnt_s == 2'd0) && !dec_seen_s;
    enc_eff    = from_prv ? prv_cnt_s : enc_cnt_s;
    height_eff = (from_prv || neg_s) ? 16'd0 : height_s;
    usecase    = dec_seen_s ? cvuc_pkg::UC_DECODE : cvuc_pkg::UC_NONE;
    if (enc_eff == 2'd2) begin
      usecase = cvuc_pkg::UC_ENC_MANY;
    end else if (enc_eff == 2'd1) begin
      if (height_eff <= limits.small_limit) begin
        usecase = cvuc_pkg::UC_ENC_SMALL;
      end else if (height_eff <= limits.mid_limit) begin
        usecase = cvuc_pkg::UC_ENC_MID;
      end else begin
        usecase = cvuc_pkg::UC_ENC_LARGE;
      end
    end
    if (enc_eff != 2'd0 && dec_seen_s) begin
      usecase = cvuc_pkg::UC_ENC_DEC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_pos_r  <= 4'd0;
      dec_pos_r  <= 4'd0;
      prv_pos_r  <= 4'd0;
      hkey_pos_r <= 3'd0;
      enc_cnt_r  <= 2'd0;
      dec_seen_r <= 1'b0;
      prv_cnt_r  <= 2'd0;
      phase_r    <= HP_KEY;
      neg_r      <= 1'b0;
      height_r   <= 16'd0;
      ended_r    <= 1'b0;
    end else if (beat.step) begin
      enc_pos_r  <= enc_pos_nxt;
      dec_pos_r  <= dec_pos_nxt;
      prv_pos_r  <= prv_pos_nxt;
      hkey_pos_r <= hkey_pos_nxt;
      enc_cnt_r  <= enc_cnt_nxt;
      dec_seen_r <= dec_seen_nxt;
      prv_cnt_r  <= prv_cnt_nxt;
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      height_r   <= height_nxt;
      ended_r    <= ended_nxt;
    end
  end

endmodule
